[rtl/slfo_pkg.sv]
// Shared constants for the step-sequencer LFO.
// No dependencies; used by the blend unit and the top level.
`timescale 1ns / 1ps

package slfo_pkg;

	// request function codes
	localparam logic [1:0] FN_TICK    = 2'd0;
	localparam logic [1:0] FN_WRITE   = 2'd1;
	localparam logic [1:0] FN_RESTART = 2'd2;
	localparam logic [1:0] FN_UNUSED  = 2'd3;

	// configuration register indexes (byte address / 4)
	localparam logic [1:0] RG_PHASE_INC  = 2'd0;
	localparam logic [1:0] RG_STEP_COUNT = 2'd1;
	localparam logic [1:0] RG_SMOOTH     = 2'd2;
	localparam logic [1:0] RG_ONE_SHOT   = 2'd3;

	// phase fixed point, 24 fractional bits
	localparam logic [24:0] ONE_Q24  = 25'd16777216;
	localparam logic [24:0] HALF_Q24 = 25'd8388608;

endpackage

[rtl/slfo_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module slfo_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/slfo_div.sv]
// Radix-2 restoring divider for the crossfade weight: quo = num * 2^24 / den.
// Flags saturation when the quotient would reach 2^24. No dependencies.
`timescale 1ns / 1ps

module slfo_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [24:0] num,
	input  logic [24:0] den,
	output logic        done,
	output logic [23:0] quo,
	output logic        sat
);

	logic        busy_q;
	logic        done_q;
	logic        sat_q;
	logic [4:0]  cnt_q;
	logic [24:0] rem_q;
	logic [23:0] quo_q;
	logic [25:0] rem2;
	logic        ge;

	assign rem2 = {rem_q, 1'b0};
	assign ge   = rem2 >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= start ? (num >= den) : (busy_q && cnt_q == 5'd23);
			if (start) begin
				cnt_q <= '0;
				if (num < den) begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd23) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sat_q <= num >= den;
			rem_q <= num;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? 25'(rem2 - {1'b0, den}) : rem2[24:0];
			quo_q <= {quo_q[22:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign sat  = sat_q;

endmodule

[rtl/slfo_blend.sv]
// History blend: B-spline/linear mix, edge crossfade or decay, then round and clamp.
// Uses slfo_pkg, slfo_div and one shared multiply-accumulate step sequence.
`timescale 1ns / 1ps

module slfo_blend (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [24:0]        p,
	input  logic signed [15:0] h0,
	input  logic signed [15:0] h1,
	input  logic signed [15:0] h2,
	input  logic signed [14:0] smooth,
	output logic               done,
	output logic signed [15:0] level
);

	localparam logic [2:0] BL_IDLE = 3'd0;
	localparam logic [2:0] BL_DIV  = 3'd1;
	localparam logic [2:0] BL_MUL  = 3'd2;
	localparam logic [2:0] BL_ACC  = 3'd3;
	localparam logic [2:0] BL_RND  = 3'd4;

	logic [2:0]         st_q;
	logic [2:0]         u_q;
	logic               done_q;
	logic signed [15:0] level_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] prod_s1;
	logic [24:0]        m2_q;
	logic [24:0]        cf_q;
	logic signed [45:0] qbs_q;
	logic signed [45:0] lin_q;

	logic               bsp, xf, dcy_lo, p_gt, neg_d;
	logic signed [15:0] s16, kq;
	logic [24:0]        den, num;
	logic               div_start, div_done, div_sat;
	logic [23:0]        div_quo;
	logic [25:0]        hq;
	logic [24:0]        cf_n;
	logic signed [27:0] c1, c2;
	logic signed [16:0] d01, d10, d12, d21;
	logic signed [26:0] pterm;
	logic signed [17:0] a_m;
	logic signed [45:0] b_m;
	logic               sh_m, first_m, last_fin;
	logic signed [63:0] base_m, acc_n, rnd_sum, r;

	assign bsp    = smooth > 15'sd4096;
	assign xf     = !bsp && (smooth >= 15'sd0);
	assign dcy_lo = smooth <= -15'sd4096;
	assign neg_d  = smooth < -15'sd8192;
	assign p_gt   = p > slfo_pkg::HALF_Q24;
	assign s16    = 16'(smooth);

	// decay/crossfade denominator: k * 4096 + 168
	always_comb begin
		if (xf) begin
			kq = s16;
		end else if (!dcy_lo) begin
			kq = -s16;
		end else begin
			kq = s16 + 16'sd8192;
		end
	end
	assign den = {kq[12:0], 12'd168};
	assign num = ((xf && !p_gt) || dcy_lo) ? p : 25'(slfo_pkg::ONE_Q24 - p);

	assign div_start = (st_q == BL_IDLE) && start && !bsp && !neg_d;

	slfo_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num),
		.den   (den),
		.done  (div_done),
		.quo   (div_quo),
		.sat   (div_sat)
	);

	// clamp the weight to [0, one]
	assign hq = 26'(slfo_pkg::HALF_Q24) + 26'(div_quo);
	always_comb begin
		if (xf && p_gt) begin
			cf_n = (div_sat || hq > 26'(slfo_pkg::ONE_Q24)) ? slfo_pkg::ONE_Q24 : hq[24:0];
		end else if (xf) begin
			cf_n = (div_sat || 25'(div_quo) > slfo_pkg::HALF_Q24) ? 25'd0 :
				25'(slfo_pkg::HALF_Q24 - 25'(div_quo));
		end else begin
			cf_n = div_sat ? slfo_pkg::ONE_Q24 : 25'(div_quo);
		end
	end

	// spline coefficients
	assign c1 = $signed({3'b0, slfo_pkg::ONE_Q24}) + $signed({2'b0, p, 1'b0})
		- $signed({2'b0, m2_q, 1'b0});
	assign c2 = $signed({3'b0, m2_q}) - $signed({2'b0, p, 1'b0})
		+ $signed({3'b0, slfo_pkg::ONE_Q24});
	assign d01 = 17'(h0) - 17'(h1);
	assign d10 = 17'(h1) - 17'(h0);
	assign d12 = 17'(h1) - 17'(h2);
	assign d21 = 17'(h2) - 17'(h1);
	assign pterm = p_gt ? $signed({2'b0, p}) - $signed({2'b0, slfo_pkg::HALF_Q24})
		: $signed({2'b0, p}) + $signed({2'b0, slfo_pkg::HALF_Q24});

	// operand selection per step
	always_comb begin
		a_m      = '0;
		b_m      = '0;
		sh_m     = 1'b0;
		first_m  = 1'b0;
		base_m   = '0;
		last_fin = 1'b0;
		if (bsp) begin
			case (u_q)
				3'd0: begin
					a_m     = $signed({5'b0, p[24:12]});
					b_m     = $signed({21'b0, p});
					sh_m    = 1'b1;
					first_m = 1'b1;
				end
				3'd1: begin
					a_m = $signed({6'b0, p[11:0]});
					b_m = $signed({21'b0, p});
				end
				3'd2: begin
					a_m     = 18'(h0);
					b_m     = $signed({21'b0, m2_q});
					first_m = 1'b1;
				end
				3'd3: begin
					a_m = 18'(h1);
					b_m = 46'(c1);
				end
				3'd4: begin
					a_m = 18'(h2);
					b_m = 46'(c2);
				end
				3'd5: begin
					a_m     = p_gt ? 18'(d01) : 18'(d12);
					b_m     = 46'(pterm);
					first_m = 1'b1;
					base_m  = (p_gt ? 64'(h1) : 64'(h2)) <<< 24;
				end
				3'd6: begin
					a_m     = (18'sd8192 - 18'(smooth)) <<< 1;
					b_m     = lin_q;
					first_m = 1'b1;
				end
				3'd7: begin
					a_m      = 18'(smooth) - 18'sd4096;
					b_m      = qbs_q;
					last_fin = 1'b1;
				end
				default: begin
					a_m = '0;
				end
			endcase
		end else begin
			first_m  = 1'b1;
			last_fin = 1'b1;
			if (xf) begin
				a_m    = p_gt ? 18'(d10) : 18'(d21);
				b_m    = $signed({21'b0, cf_q});
				base_m = (p_gt ? 64'(h0) : 64'(h1)) <<< 24;
			end else if (!dcy_lo) begin
				a_m = 18'(h1);
				b_m = $signed({21'b0, cf_q});
			end else begin
				a_m = 18'(h1);
				b_m = $signed({21'b0, 25'(slfo_pkg::ONE_Q24 - cf_q)});
			end
		end
	end

	assign acc_n   = (first_m ? base_m : acc_q) + prod_s1;
	assign rnd_sum = acc_q + (bsp ? (64'sd1 <<< 36) : (64'sd1 <<< 23));
	assign r       = bsp ? (rnd_sum >>> 37) : (rnd_sum >>> 24);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= BL_IDLE;
			u_q    <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (st_q == BL_RND);
			case (st_q)
				BL_IDLE: begin
					u_q <= '0;
					if (start) begin
						st_q <= (bsp || neg_d) ? BL_MUL : BL_DIV;
					end
				end
				BL_DIV: begin
					if (div_done) begin
						st_q <= BL_MUL;
					end
				end
				BL_MUL: begin
					st_q <= BL_ACC;
				end
				BL_ACC: begin
					u_q  <= u_q + 3'd1;
					st_q <= last_fin ? BL_RND : BL_MUL;
				end
				BL_RND: begin
					st_q <= BL_IDLE;
				end
				default: begin
					st_q <= BL_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == BL_IDLE && start && neg_d && !bsp) begin
			cf_q <= '0;
		end else if (st_q == BL_DIV && div_done) begin
			cf_q <= cf_n;
		end
		if (st_q == BL_MUL) begin
			prod_s1 <= sh_m ? ((64'(a_m) * 64'(b_m)) <<< 12) : (64'(a_m) * 64'(b_m));
		end
		if (st_q == BL_ACC) begin
			acc_q <= acc_n;
			if (bsp && u_q == 3'd1) begin
				m2_q <= acc_n[48:24];
			end
			if (bsp && u_q == 3'd4) begin
				qbs_q <= acc_n[45:0];
			end
			if (bsp && u_q == 3'd5) begin
				lin_q <= acc_n[45:0];
			end
		end
		if (st_q == BL_RND) begin
			if (r > 64'sd32767) begin
				level_q <= 16'sd32767;
			end else if (r < -64'sd32768) begin
				level_q <= -16'sd32768;
			end else begin
				level_q <= r[15:0];
			end
		end
	end

	assign done  = done_q;
	assign level = level_q;

endmodule

[rtl/step_sequencer_lfo.sv]
// Step-sequencer LFO top: config registers, step table RAM, step/phase sequencer.
// Table write: taken on accept. Restart: three table reads, each a read then a write-back.
// Tick: accept, one table RAM read per step advance, start the blend, then blend with
// B-spline mixing (eight MAC steps) or crossfade/decay through the divider, which ends
// early when the weight saturates and is skipped below minus two; then load the result.
// Reset: registers to their defaults; table reads as zero until an entry is written.
`timescale 1ns / 1ps

module step_sequencer_lfo #(
	parameter int TABLE_STEPS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// APB configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// request channel
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         func,
	input  logic [4:0]         entry_index,
	input  logic signed [15:0] entry_value,
	// result channel
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [15:0] level,
	output logic [4:0]         current_step_out
);

	localparam int AW = $clog2(TABLE_STEPS);
	localparam int CW = AW + 1;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_RS_RD  = 3'd1;
	localparam logic [2:0] ST_RS_WB  = 3'd2;
	localparam logic [2:0] ST_TK_CHK = 3'd3;
	localparam logic [2:0] ST_TK_WB  = 3'd4;
	localparam logic [2:0] ST_TK_BL  = 3'd5;
	localparam logic [2:0] ST_TK_OUT = 3'd6;

	// configuration
	logic [25:0]        phase_inc_q;
	logic [5:0]         step_count_q;
	logic signed [14:0] smooth_q;
	logic               one_shot_q;

	// sequencer state
	logic [2:0]         st_q;
	logic [AW-1:0]      step_q;
	logic [26:0]        phase_q;
	logic signed [15:0] hist_q [3];
	logic [AW-1:0]      rs_idx_q;
	logic [1:0]         rs_k_q;
	logic               vld_q [TABLE_STEPS];
	logic               rd_vld_s1;

	// result register
	logic               res_valid_q;
	logic signed [15:0] level_q;
	logic [4:0]         step_out_q;

	logic               accept, wr_en, cfg_wr;
	logic [CW-1:0]      cnt, nxt_w;
	logic [AW-1:0]      step_nxt, raddr, rs_prev;
	logic [15:0]        ram_rdata;
	logic signed [15:0] tbl_val;
	logic               bl_start, bl_done, out_free;
	logic signed [15:0] bl_level;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_inc_q  <= '0;
			step_count_q <= 6'd16;
			smooth_q     <= '0;
			one_shot_q   <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				slfo_pkg::RG_PHASE_INC:  phase_inc_q  <= pwdata[25:0];
				slfo_pkg::RG_STEP_COUNT: step_count_q <= pwdata[5:0];
				slfo_pkg::RG_SMOOTH:     smooth_q     <= pwdata[14:0];
				slfo_pkg::RG_ONE_SHOT:   one_shot_q   <= pwdata[0];
				default:                 one_shot_q   <= one_shot_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			slfo_pkg::RG_PHASE_INC:  prdata = {6'b0, phase_inc_q};
			slfo_pkg::RG_STEP_COUNT: prdata = {26'b0, step_count_q};
			slfo_pkg::RG_SMOOTH:     prdata = {17'b0, smooth_q};
			slfo_pkg::RG_ONE_SHOT:   prdata = {31'b0, one_shot_q};
			default:                 prdata = '0;
		endcase
	end

	// effective loop length: zero acts as one, clamped to the table size
	always_comb begin
		if (step_count_q == 6'd0) begin
			cnt = CW'(1);
		end else if (32'(step_count_q) > 32'(TABLE_STEPS)) begin
			cnt = CW'(TABLE_STEPS);
		end else begin
			cnt = CW'(step_count_q);
		end
	end

	// next step: hold at the last step in one-shot mode, else wrap
	assign nxt_w = {1'b0, step_q} + CW'(1);
	always_comb begin
		if (one_shot_q && nxt_w > cnt - CW'(1)) begin
			step_nxt = AW'(cnt - CW'(1));
		end else if (!one_shot_q && nxt_w >= cnt) begin
			step_nxt = '0;
		end else begin
			step_nxt = AW'(nxt_w);
		end
	end

	assign rs_prev = (rs_idx_q == '0) ? AW'(cnt - CW'(1)) : rs_idx_q - AW'(1);

	assign item_stall = (st_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign wr_en      = accept && func == slfo_pkg::FN_WRITE
		&& 32'(entry_index) < 32'(TABLE_STEPS);
	assign raddr      = (st_q == ST_TK_CHK) ? step_nxt : rs_idx_q;

	slfo_ram #(
		.WIDTH(16),
		.DEPTH(TABLE_STEPS)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(AW'(entry_index)),
		.wdata(entry_value),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// entries never written read as zero
	assign tbl_val = rd_vld_s1 ? $signed(ram_rdata) : 16'sd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_STEPS; i++) begin
				vld_q[i] <= 1'b0;
			end
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[AW'(entry_index)] <= 1'b1;
			end
			rd_vld_s1 <= vld_q[raddr];
		end
	end

	assign bl_start = (st_q == ST_TK_CHK) && !(phase_q > 27'(slfo_pkg::ONE_Q24));
	assign out_free = !res_valid_q || !result_stall;

	slfo_blend u_blend (
		.clk   (clk),
		.arst_n(arst_n),
		.start (bl_start),
		.p     (phase_q[24:0]),
		.h0    (hist_q[0]),
		.h1    (hist_q[1]),
		.h2    (hist_q[2]),
		.smooth(smooth_q),
		.done  (bl_done),
		.level (bl_level)
	);

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			step_q      <= AW'(1);
			phase_q     <= '0;
			rs_idx_q    <= '0;
			rs_k_q      <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			// taken result; a new one loading in the same cycle is handled below
			if (res_valid_q && !result_stall && st_q != ST_TK_OUT) begin
				res_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (accept && func == slfo_pkg::FN_RESTART) begin
						// step = 1 mod count, preload history walking backwards
						step_q   <= (cnt == CW'(1)) ? '0 : AW'(1);
						rs_idx_q <= (cnt == CW'(1)) ? '0 : AW'(1);
						rs_k_q   <= '0;
						phase_q  <= '0;
						st_q     <= ST_RS_RD;
					end else if (accept && func == slfo_pkg::FN_TICK) begin
						phase_q <= phase_q + 27'(phase_inc_q);
						st_q    <= ST_TK_CHK;
					end
				end
				ST_RS_RD: begin
					st_q <= ST_RS_WB;
				end
				ST_RS_WB: begin
					hist_q[rs_k_q] <= tbl_val;
					rs_idx_q       <= rs_prev;
					rs_k_q         <= rs_k_q + 2'd1;
					st_q           <= (rs_k_q == 2'd2) ? ST_IDLE : ST_RS_RD;
				end
				ST_TK_CHK: begin
					if (phase_q > 27'(slfo_pkg::ONE_Q24)) begin
						step_q  <= step_nxt;
						phase_q <= phase_q - 27'(slfo_pkg::ONE_Q24);
						st_q    <= ST_TK_WB;
					end else begin
						st_q <= ST_TK_BL;
					end
				end
				ST_TK_WB: begin
					hist_q[2] <= hist_q[1];
					hist_q[1] <= hist_q[0];
					hist_q[0] <= tbl_val;
					st_q      <= ST_TK_CHK;
				end
				ST_TK_BL: begin
					if (bl_done) begin
						st_q <= ST_TK_OUT;
					end
				end
				ST_TK_OUT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_TK_OUT && out_free) begin
			level_q    <= bl_level;
			step_out_q <= 5'(step_q);
		end
	end

	assign result_valid     = res_valid_q;
	assign level            = level_q;
	assign current_step_out = step_out_q;

endmodule
